@@ hdl/stlm_pkg.sv @@
// ----------------------------------------------------------------------------
// stlm_pkg
// Shared types and codes for the two-list sort and merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package stlm_pkg;

	localparam int VALUE_W = 32;
	localparam int FUNC_W  = 2;

	localparam logic [FUNC_W-1:0] FUNC_PUSH_A = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_B = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;

	typedef struct packed {
		logic push;
		logic clear;
		logic ld_cur;
		logic swap_chk;
		logic wr_back;
	} stlm_lane_cmd_t;

	typedef struct packed {
		logic emit;
		logic sel_a;
		logic last;
	} stlm_out_cmd_t;

	typedef struct packed {
		logic a_gt_b;
		logic out_free;
	} stlm_stat_t;

endpackage

`default_nettype wire

@@ hdl/stlm_list.sv @@
// ----------------------------------------------------------------------------
// stlm_list
// One list store: a memory with a registered read port, the fill count and
// the held element of the exchange sort.
// ----------------------------------------------------------------------------
`default_nettype none

module stlm_list #(
	parameter int LIST_DEPTH = 32,
	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
	localparam int CW = $clog2(LIST_DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stlm_pkg::stlm_lane_cmd_t     cmd,
	input  logic [stlm_pkg::VALUE_W-1:0] push_data,
	input  logic [IW-1:0]                rd_addr,
	input  logic [IW-1:0]                i_addr,
	input  logic [IW-1:0]                j_addr,
	output logic [stlm_pkg::VALUE_W-1:0] rd_data,
	output logic [CW-1:0]                count,
	output logic                         full
);
	import stlm_pkg::*;

	logic [VALUE_W-1:0] mem [LIST_DEPTH];
	logic [VALUE_W-1:0] rd_data_q;
	logic [VALUE_W-1:0] cur_q;
	logic [CW-1:0]      count_q;
	logic               swap;
	logic               we;
	logic [IW-1:0]      waddr;
	logic [VALUE_W-1:0] wdata;

	assign full    = (count_q == CW'(LIST_DEPTH));
	assign swap    = cmd.swap_chk && ($signed(cur_q) > $signed(rd_data_q));
	assign rd_data = rd_data_q;
	assign count   = count_q;

	always_comb begin
		we    = 1'b0;
		waddr = i_addr;
		wdata = cur_q;
		if (cmd.push && !full) begin
			we    = 1'b1;
			waddr = count_q[IW-1:0];
			wdata = push_data;
		end else if (swap) begin
			we    = 1'b1;
			waddr = j_addr;
		end else if (cmd.wr_back) begin
			we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[rd_addr];
		if (cmd.ld_cur || swap) begin
			cur_q <= rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.push && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

endmodule

`default_nettype wire

@@ hdl/stlm_dp.sv @@
// ----------------------------------------------------------------------------
// stlm_dp
// Datapath: both list stores, the dropped-push flag and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stlm_dp #(
	parameter int LIST_DEPTH = 32,
	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
	localparam int CW = $clog2(LIST_DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  stlm_pkg::stlm_lane_cmd_t            cmd_a,
	input  stlm_pkg::stlm_lane_cmd_t            cmd_b,
	input  stlm_pkg::stlm_out_cmd_t             out_cmd,
	input  logic signed [stlm_pkg::VALUE_W-1:0] value,
	input  logic [IW-1:0]                       rd_addr_a,
	input  logic [IW-1:0]                       rd_addr_b,
	input  logic [IW-1:0]                       i_addr,
	input  logic [IW-1:0]                       j_addr,
	output logic [CW-1:0]                       count_a,
	output logic [CW-1:0]                       count_b,
	output stlm_pkg::stlm_stat_t                stat,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [stlm_pkg::VALUE_W-1:0] sorted_value,
	output logic                                last,
	output logic                                overflowed
);
	import stlm_pkg::*;

	logic [VALUE_W-1:0] rd_a;
	logic [VALUE_W-1:0] rd_b;
	logic               full_a;
	logic               full_b;
	logic               drop_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] sorted_value_q;
	logic               last_q;
	logic               overflowed_q;

	stlm_list #(.LIST_DEPTH(LIST_DEPTH)) u_list_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_a),
		.push_data (value),
		.rd_addr   (rd_addr_a),
		.i_addr    (i_addr),
		.j_addr    (j_addr),
		.rd_data   (rd_a),
		.count     (count_a),
		.full      (full_a)
	);

	stlm_list #(.LIST_DEPTH(LIST_DEPTH)) u_list_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_b),
		.push_data (value),
		.rd_addr   (rd_addr_b),
		.i_addr    (i_addr),
		.j_addr    (j_addr),
		.rd_data   (rd_b),
		.count     (count_b),
		.full      (full_b)
	);

	assign stat.a_gt_b   = ($signed(rd_a) > $signed(rd_b));
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (cmd_a.clear) begin
			drop_q <= 1'b0;
		end else if ((cmd_a.push && full_a) || (cmd_b.push && full_b)) begin
			drop_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_cmd.emit) begin
			sorted_value_q <= out_cmd.sel_a ? rd_a : rd_b;
			last_q         <= out_cmd.last;
			overflowed_q   <= drop_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign last         = last_q;
	assign overflowed   = overflowed_q;

endmodule

`default_nettype wire

@@ hdl/stlm_ctrl.sv @@
// ----------------------------------------------------------------------------
// stlm_ctrl
// Controller: accepts items, steps the exchange sort of both lists in
// lockstep and then walks the two-way merge.
// ----------------------------------------------------------------------------
`default_nettype none

module stlm_ctrl #(
	parameter int LIST_DEPTH = 32,
	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
	localparam int CW = $clog2(LIST_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [stlm_pkg::FUNC_W-1:0] func,
	output logic                        in_stall,
	input  logic [CW-1:0]               count_a,
	input  logic [CW-1:0]               count_b,
	input  stlm_pkg::stlm_stat_t        stat,
	output stlm_pkg::stlm_lane_cmd_t    cmd_a,
	output stlm_pkg::stlm_lane_cmd_t    cmd_b,
	output stlm_pkg::stlm_out_cmd_t     out_cmd,
	output logic [IW-1:0]               rd_addr_a,
	output logic [IW-1:0]               rd_addr_b,
	output logic [IW-1:0]               i_addr,
	output logic [IW-1:0]               j_addr
);
	import stlm_pkg::*;

	localparam int XW = CW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDI  = 3'd1;
	localparam logic [2:0] ST_LDI  = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_WRI  = 3'd4;
	localparam logic [2:0] ST_MRD  = 3'd5;
	localparam logic [2:0] ST_MCMP = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [IW-1:0] i_q, i_d;
	logic [IW-1:0] j_q, j_d;
	logic [CW-1:0] ja_q, ja_d;
	logic [CW-1:0] kb_q, kb_d;
	logic [CW-1:0] n_max;
	logic          accept;
	logic          j_more;
	logic          i_more;
	logic          a_av;
	logic          b_av;
	logic          sel_a;
	logic          last_res;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign i_addr   = i_q;
	assign j_addr   = j_q;

	assign n_max    = (count_a > count_b) ? count_a : count_b;
	assign j_more   = (XW'(j_q) + XW'(1)) < XW'(n_max);
	assign i_more   = (XW'(i_q) + XW'(2)) < XW'(n_max);
	assign a_av     = (ja_q < count_a);
	assign b_av     = (kb_q < count_b);
	assign sel_a    = a_av && (!b_av || !stat.a_gt_b);
	assign last_res = (XW'(ja_q) + XW'(kb_q) + XW'(1)) == (XW'(count_a) + XW'(count_b));

	always_comb begin
		state_d   = state_q;
		i_d       = i_q;
		j_d       = j_q;
		ja_d      = ja_q;
		kb_d      = kb_q;
		cmd_a     = '0;
		cmd_b     = '0;
		out_cmd   = '0;
		rd_addr_a = j_q;
		rd_addr_b = j_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_a.push = (func == FUNC_PUSH_A);
					cmd_b.push = (func == FUNC_PUSH_B);
					if (func == FUNC_RUN) begin
						i_d  = '0;
						ja_d = '0;
						kb_d = '0;
						if ((count_a == '0) && (count_b == '0)) begin
							cmd_a.clear = 1'b1;
							cmd_b.clear = 1'b1;
						end else if (n_max > CW'(1)) begin
							state_d = ST_RDI;
						end else begin
							state_d = ST_MRD;
						end
					end
				end
			end
			ST_RDI: begin
				rd_addr_a = i_q;
				rd_addr_b = i_q;
				j_d       = i_q + IW'(1);
				state_d   = ST_LDI;
			end
			ST_LDI: begin
				cmd_a.ld_cur = 1'b1;
				cmd_b.ld_cur = 1'b1;
				state_d      = ST_CMP;
			end
			ST_CMP: begin
				rd_addr_a      = j_q + IW'(1);
				rd_addr_b      = j_q + IW'(1);
				cmd_a.swap_chk = (CW'(j_q) < count_a);
				cmd_b.swap_chk = (CW'(j_q) < count_b);
				if (j_more) begin
					j_d = j_q + IW'(1);
				end else begin
					state_d = ST_WRI;
				end
			end
			ST_WRI: begin
				cmd_a.wr_back = (CW'(i_q) < count_a);
				cmd_b.wr_back = (CW'(i_q) < count_b);
				if (i_more) begin
					i_d     = i_q + IW'(1);
					state_d = ST_RDI;
				end else begin
					ja_d    = '0;
					kb_d    = '0;
					state_d = ST_MRD;
				end
			end
			ST_MRD: begin
				rd_addr_a = ja_q[IW-1:0];
				rd_addr_b = kb_q[IW-1:0];
				state_d   = ST_MCMP;
			end
			ST_MCMP: begin
				rd_addr_a = ja_q[IW-1:0];
				rd_addr_b = kb_q[IW-1:0];
				if (stat.out_free) begin
					out_cmd.emit  = 1'b1;
					out_cmd.sel_a = sel_a;
					out_cmd.last  = last_res;
					if (sel_a) begin
						ja_d = ja_q + CW'(1);
					end else begin
						kb_d = kb_q + CW'(1);
					end
					if (last_res) begin
						cmd_a.clear = 1'b1;
						cmd_b.clear = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						state_d = ST_MRD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			ja_q    <= '0;
			kb_q    <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			ja_q    <= ja_d;
			kb_q    <= kb_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/sort_two_lists_and_merge_unit.sv @@
// ----------------------------------------------------------------------------
// sort_two_lists_and_merge_unit
// Collects signed values into two lists, sorts each on a run item and emits
// the two-way merge in ascending order, list A first on equal values.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Fields
//   input     in_valid / in_stall    func, value
//   output    out_valid / out_stall  sorted_value, last, overflowed
//
// A push item, an ignored code and an empty run are each taken in the idle state.
// A run with N = max(count_a, count_b) sorts the first N places of each list
// by lockstep exchange sort, then takes a read state and a compare state per
// result, both set by the single registered read port of each list memory.
// Reset needs no clearing pass; list contents are only used once written.
// Output stalls hold the merge; the input stalls for the whole of a run.
//
`default_nettype none

module sort_two_lists_and_merge_unit #(
	parameter int LIST_DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [stlm_pkg::FUNC_W-1:0]         func,
	input  logic signed [stlm_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [stlm_pkg::VALUE_W-1:0] sorted_value,
	output logic                                last,
	output logic                                overflowed
);
	import stlm_pkg::*;

	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);

	stlm_lane_cmd_t cmd_a;
	stlm_lane_cmd_t cmd_b;
	stlm_out_cmd_t  out_cmd;
	stlm_stat_t     stat;
	logic [IW-1:0]  rd_addr_a;
	logic [IW-1:0]  rd_addr_b;
	logic [IW-1:0]  i_addr;
	logic [IW-1:0]  j_addr;
	logic [CW-1:0]  count_a;
	logic [CW-1:0]  count_b;

	stlm_ctrl #(.LIST_DEPTH(LIST_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.in_stall  (in_stall),
		.count_a   (count_a),
		.count_b   (count_b),
		.stat      (stat),
		.cmd_a     (cmd_a),
		.cmd_b     (cmd_b),
		.out_cmd   (out_cmd),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.i_addr    (i_addr),
		.j_addr    (j_addr)
	);

	stlm_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_a        (cmd_a),
		.cmd_b        (cmd_b),
		.out_cmd      (out_cmd),
		.value        (value),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.i_addr       (i_addr),
		.j_addr       (j_addr),
		.count_a      (count_a),
		.count_b      (count_b),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.last         (last),
		.overflowed   (overflowed)
	);

endmodule

`default_nettype wire

@@ hdl/stlm_chk.sv @@
// ----------------------------------------------------------------------------
// stlm_chk
// Port checker for the sort and merge unit: output beat protocol, ascending
// order within a run and a steady overflow flag across a run.
// ----------------------------------------------------------------------------
`default_nettype none

module stlm_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [stlm_pkg::VALUE_W-1:0] sorted_value,
	input logic                                last,
	input logic                                overflowed
);
	import stlm_pkg::*;

	logic               open_q;
	logic [VALUE_W-1:0] prev_value_q;
	logic               prev_ovf_q;
	logic               out_beat;

	assign out_beat = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (out_beat) begin
			open_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_beat) begin
			prev_value_q <= sorted_value;
			prev_ovf_q   <= overflowed;
		end
	end

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Output beat withdrawn while stalled.");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(sorted_value) && $stable(last) &&
			$stable(overflowed))
		else $error("Output payload changed while stalled.");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && open_q |-> $signed(sorted_value) >= $signed(prev_value_q))
		else $error("Merged run is not in ascending order.");

	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && open_q |-> overflowed == prev_ovf_q)
		else $error("Overflow flag changed within a run.");

endmodule

bind sort_two_lists_and_merge_unit stlm_chk u_stlm_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sorted_value (sorted_value),
	.last         (last),
	.overflowed   (overflowed)
);

`default_nettype wire
